/* design/spq_pkg.sv */
package spq_pkg;

  // Queue geometry.
  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned PRIO_BITS = 16;
  localparam int unsigned IDX_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);

  // Fixed field widths of the stream items.
  localparam int unsigned SRC_W       = 8;
  localparam int unsigned DEST_W      = 8;
  localparam int unsigned PRIO_W      = 16;
  localparam int unsigned FILL_W      = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned S_TDATA_W   = 32;
  localparam int unsigned M_TDATA_W   = 40;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [PRIO_BITS-1:0] prio;
    logic [DEST_W-1:0]    dest;
    logic [SRC_W-1:0]     src;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Result handed from the sequencer to the output stage.
  typedef struct packed {
    logic             head_valid;
    entry_t           head;
    logic [CNT_W-1:0] fill;
    status_e          status;
  } result_t;

endpackage

/* design/spq_ram.sv */
module spq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/spq_seq.sv */
module spq_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Command side.
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  spq_pkg::cmd_e                cmd_i,
  input  spq_pkg::entry_t              cmd_entry_i,
  // Result side.
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output spq_pkg::result_t             res_o,
  // Slot memory.
  output logic                         mem_we_o,
  output logic [spq_pkg::IDX_W-1:0]    mem_waddr_o,
  output spq_pkg::entry_t              mem_wdata_o,
  output logic                         mem_re_o,
  output logic [spq_pkg::IDX_W-1:0]    mem_raddr_o,
  input  spq_pkg::entry_t              mem_rdata_i
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_PUSH_RD  = 7'b0000010,
    S_PUSH_CMP = 7'b0000100,
    S_POP_RD   = 7'b0001000,
    S_POP_WR   = 7'b0010000,
    S_HEAD_RD  = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  state_e                        state_q, state_d;
  logic [spq_pkg::CNT_W-1:0]     count_q, count_d;
  logic [spq_pkg::IDX_W-1:0]     idx_q, idx_d;
  spq_pkg::entry_t               new_q, new_d;
  spq_pkg::status_e              status_q, status_d;
  logic                          greater;

  // The one shared comparator: does the stored entry rank behind the new one?
  assign greater = mem_rdata_i.prio > new_q.prio;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    new_d       = new_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = new_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          new_d = cmd_entry_i;
          idx_d = '0;
          if (cmd_i == spq_pkg::CMD_PUSH) begin
            if (count_q == spq_pkg::CNT_W'(spq_pkg::CAPACITY)) begin
              status_d = spq_pkg::ST_FULL;
              state_d  = S_HEAD_RD;
            end else begin
              status_d = spq_pkg::ST_OK;
              idx_d    = count_q[spq_pkg::IDX_W-1:0];
              state_d  = S_PUSH_RD;
            end
          end else begin
            if (count_q == '0) begin
              status_d = spq_pkg::ST_EMPTY;
              state_d  = S_HEAD_RD;
            end else begin
              status_d = spq_pkg::ST_OK;
              count_d  = count_q - 1'b1;
              state_d  = S_POP_RD;
            end
          end
        end
      end
      S_PUSH_RD: begin
        if (idx_q == '0) begin
          mem_we_o = 1'b1;
          count_d  = count_q + 1'b1;
          state_d  = S_HEAD_RD;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q - 1'b1;
          state_d     = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        mem_we_o = 1'b1;
        if (greater) begin
          // Move the larger entry one slot toward the tail and keep looking.
          mem_wdata_o = mem_rdata_i;
          idx_d       = idx_q - 1'b1;
          state_d     = S_PUSH_RD;
        end else begin
          count_d = count_q + 1'b1;
          state_d = S_HEAD_RD;
        end
      end
      S_POP_RD: begin
        // count_q already holds the count after the pop.
        if (spq_pkg::CNT_W'(idx_q) >= count_q) begin
          state_d = S_HEAD_RD;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + 1'b1;
          state_d     = S_POP_WR;
        end
      end
      S_POP_WR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        idx_d       = idx_q + 1'b1;
        state_d     = S_POP_RD;
      end
      S_HEAD_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = '0;
        state_d     = S_DONE;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // An empty queue reports a zero head.
  always_comb begin
    res_o.head_valid = count_q != '0;
    res_o.head       = (count_q != '0) ? mem_rdata_i : '0;
    res_o.fill       = count_q;
    res_o.status     = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      status_q <= spq_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
  end

endmodule

/* design/sorted_priority_queue_top.sv */
// Sorted minimum-first priority queue with a stream interface.
//
// The slave channel takes one command item at a time: tuser selects push
// (0) or pop (1), and tdata carries the entry to push. The master channel
// returns exactly one result item per command: the head entry after the
// command, its valid flag in tuser, the fill count and a status code that
// flags a push dropped on a full queue or a pop on an empty one. Entries of
// equal priority leave in the order they arrived.
//
// Entries live in a small single-port-read RAM, kept sorted with the head
// in slot zero. A sequencer moves one entry at a time through a single
// comparator: a push walks from the tail toward its place, a pop shifts
// every remaining entry down by one. s_axis_tready_o is high only while the
// sequencer is idle. Reset clears the fill count and the control state; the
// RAM contents are not cleared and are never used before being written.
// When the receiver stalls, the result sits in the output register and the
// next command can still be accepted; its result waits until the register
// is free.
module sorted_priority_queue_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // Fields from bit 0: item_src[7:0], item_dest[15:8], item_priority[31:16].
  input  logic [spq_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // Fields from bit 0: cmd[0].
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // Fields from bit 0: head_src[7:0], head_dest[15:8], head_priority[31:16],
  // fill_count[36:32], status[38:37], zero padding[39].
  output logic [spq_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // Fields from bit 0: head_valid[0].
  output logic                            m_axis_tuser_o
);

  spq_pkg::entry_t                 cmd_entry;
  spq_pkg::result_t                res;
  logic                            res_valid;
  logic                            res_ready;
  logic                            mem_we;
  logic                            mem_re;
  logic [spq_pkg::IDX_W-1:0]       mem_waddr;
  logic [spq_pkg::IDX_W-1:0]       mem_raddr;
  spq_pkg::entry_t                 mem_wdata;
  spq_pkg::entry_t                 mem_rdata;

  logic                            out_valid_q, out_valid_d;
  spq_pkg::result_t                out_q;

  // The priority is cut or widened to the stored width.
  assign cmd_entry.src  = s_axis_tdata_i[7:0];
  assign cmd_entry.dest = s_axis_tdata_i[15:8];
  assign cmd_entry.prio = spq_pkg::PRIO_BITS'(s_axis_tdata_i[31:16]);

  spq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid_i),
    .cmd_ready_o (s_axis_tready_o),
    .cmd_i       (spq_pkg::cmd_e'(s_axis_tuser_i)),
    .cmd_entry_i (cmd_entry),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  spq_ram #(
    .WIDTH (spq_pkg::ENTRY_W),
    .DEPTH (spq_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The output register takes a new result whenever it is empty or being
  // drained in the same cycle.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.head_valid;
  assign m_axis_tdata_o  = {1'b0,
                            out_q.status,
                            spq_pkg::FILL_W'(out_q.fill),
                            spq_pkg::PRIO_W'(out_q.head.prio),
                            out_q.head.dest,
                            out_q.head.src};

endmodule

/* test/sorted_priority_queue_top_test.sv */
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;

  // Receiver and drain timing.
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT      = 4000;
  localparam int unsigned SETTLE_CYCLES    = 48;
  localparam int unsigned MAX_REPORTED     = 10;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [spq_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                          s_tuser = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [spq_pkg::M_TDATA_W-1:0] m_tdata;
  logic                          m_tuser;

  // Idling controls shared by the sender, the receiver and the test tasks.
  bit          tx_gap_en   = 1'b1;
  bit          rx_stall_en = 1'b1;
  int unsigned hold_cycles = 0;

  // Shadow copy of the queue contents and the head reports still owed by the block.
  spq_pkg::entry_t  shadow_slots[spq_pkg::CAPACITY];
  int unsigned      shadow_count = 0;
  spq_pkg::result_t head_reports_due[$];
  int unsigned      fail_count = 0;

  sorted_priority_queue_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #5 clk = ~clk;

  // Applies one command to the shadow queue and returns the head report it produces.
  // A new entry goes behind every entry of lower or equal priority.
  function automatic spq_pkg::result_t apply_to_shadow_queue(spq_pkg::cmd_e cmd,
                                                             spq_pkg::entry_t item);
    spq_pkg::result_t report;
    int unsigned      pos;
    report.status = spq_pkg::ST_OK;
    if (cmd == spq_pkg::CMD_PUSH) begin
      if (shadow_count >= spq_pkg::CAPACITY) begin
        report.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_slots[pos].prio <= item.prio) pos++;
        for (int unsigned i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[pos] = item;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      report.status = spq_pkg::ST_EMPTY;
    end else begin
      for (int unsigned i = 0; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i+1];
      shadow_count--;
    end
    report.head_valid = (shadow_count != 0);
    report.head       = report.head_valid ? shadow_slots[0] : '0;
    report.fill       = spq_pkg::CNT_W'(shadow_count);
    return report;
  endfunction

  // Offers one item, possibly after a random gap, and waits for its handshake.
  // The task is always entered at a rising edge and leaves at the accepting edge.
  task automatic send_item(spq_pkg::cmd_e cmd, spq_pkg::entry_t item);
    if (tx_gap_en && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    head_reports_due.push_back(apply_to_shadow_queue(cmd, item));
  endtask

  // Stops offering items until every owed report has come back, then lets the block settle.
  task automatic wait_for_results();
    int unsigned waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (head_reports_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Priorities lean toward the extremes and a narrow band so that ties are common.
  function automatic logic [spq_pkg::PRIO_W-1:0] pick_priority();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return spq_pkg::PRIO_W'($urandom_range(0, 7));
      default: return spq_pkg::PRIO_W'($urandom);
    endcase
  endfunction

  function automatic spq_pkg::entry_t random_entry();
    spq_pkg::entry_t item;
    item.src  = spq_pkg::SRC_W'($urandom);
    item.dest = spq_pkg::DEST_W'($urandom);
    item.prio = pick_priority();
    return item;
  endfunction

  // Receiver: random stall bursts, plus one long hold-off when a test asks for it.
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compares every accepted result with the oldest owed report, field by field.
  always @(posedge clk) begin
    spq_pkg::result_t got;
    spq_pkg::result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got.head_valid = m_tuser;
      got.head       = spq_pkg::entry_t'(m_tdata[31:0]);
      got.fill       = m_tdata[36:32];
      got.status     = spq_pkg::status_e'(m_tdata[38:37]);
      if (head_reports_due.size() == 0) begin
        if (fail_count < MAX_REPORTED)
          $display("%0t: result with no command pending: valid %0d src %0h dest %0h prio %0h",
                   $realtime, got.head_valid, got.head.src, got.head.dest, got.head.prio);
        fail_count++;
      end else begin
        want = head_reports_due.pop_front();
        if (got.head_valid !== want.head_valid || got.head.src !== want.head.src ||
            got.head.dest !== want.head.dest || got.head.prio !== want.head.prio ||
            got.fill !== want.fill || got.status !== want.status) begin
          if (fail_count < MAX_REPORTED) begin
            $display("%0t: mismatch, expected valid %0d src %0h dest %0h prio %0h fill %0d st %0d",
                     $realtime, want.head_valid, want.head.src, want.head.dest, want.head.prio,
                     want.fill, want.status);
            $display("%0t:           actual valid %0d src %0h dest %0h prio %0h fill %0d st %0d",
                     $realtime, got.head_valid, got.head.src, got.head.dest, got.head.prio,
                     got.fill, got.status);
          end
          fail_count++;
        end
      end
    end
  end

  // Pops on an empty queue, before and after a single entry has passed through.
  task automatic test_pop_on_empty();
    send_item(spq_pkg::CMD_POP, '{prio: 16'h1234, dest: 8'h00, src: 8'hFF});
    send_item(spq_pkg::CMD_PUSH, '{prio: 16'h0003, dest: 8'h09, src: 8'h07});
    send_item(spq_pkg::CMD_POP, '0);
    send_item(spq_pkg::CMD_POP, '1);
  endtask

  // Fills the queue with extreme field values and ties at the lowest, a middle
  // and the highest priority, pushes once more into the full queue, then pops a few.
  task automatic test_fill_and_overflow();
    logic [spq_pkg::PRIO_W-1:0] tie_prio;
    send_item(spq_pkg::CMD_PUSH, '{prio: 16'hFFFF, dest: 8'h00, src: 8'h00});
    send_item(spq_pkg::CMD_PUSH, '{prio: 16'h0000, dest: 8'hFF, src: 8'hFF});
    send_item(spq_pkg::CMD_PUSH, '{prio: 16'h8000, dest: 8'h5A, src: 8'hA5});
    send_item(spq_pkg::CMD_PUSH, '{prio: 16'h7FFF, dest: 8'hA5, src: 8'h5A});
    for (int i = 0; i < 12; i++) begin
      case (i % 3)
        0:       tie_prio = 16'h0100;
        1:       tie_prio = 16'h0000;
        default: tie_prio = 16'hFFFF;
      endcase
      send_item(spq_pkg::CMD_PUSH,
                '{prio: tie_prio, dest: ~(8'h10 + 8'(i)), src: 8'h10 + 8'(i)});
    end
    // This entry ties the lowest priority and would queue behind its equals if the full queue took it.
    send_item(spq_pkg::CMD_PUSH, '{prio: 16'h0000, dest: 8'h11, src: 8'hEE});
    repeat (4) send_item(spq_pkg::CMD_POP, random_entry());
  endtask

  // Bursts that lean toward pushes, toward pops or neither, so the queue swings between
  // empty and full. Pops carry random payload that the block must ignore.
  task automatic test_random_traffic(int unsigned num_items);
    int unsigned sent;
    int unsigned burst_len;
    int unsigned push_pct;
    sent = 0;
    while (sent < num_items) begin
      burst_len = $urandom_range(8, 48);
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      for (int unsigned j = 0; j < burst_len && sent < num_items; j++) begin
        send_item(($urandom_range(0, 99) < push_pct) ? spq_pkg::CMD_PUSH : spq_pkg::CMD_POP,
                  random_entry());
        sent++;
      end
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items, so the output register fills and the block must stall its input.
  task automatic test_output_backpressure();
    bit saved_gap_en;
    saved_gap_en = tx_gap_en;
    tx_gap_en    = 1'b0;
    hold_cycles  = LONG_HOLD_CYCLES;
    repeat (48) send_item(($urandom_range(0, 9) < 7) ? spq_pkg::CMD_PUSH : spq_pkg::CMD_POP,
                          random_entry());
    tx_gap_en = saved_gap_en;
    wait_for_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pop_on_empty();
    test_fill_and_overflow();
    wait_for_results();
    test_random_traffic(1300);
    test_output_backpressure();
    // Last stretch runs back to back with no idling on either side.
    tx_gap_en   = 1'b0;
    rx_stall_en = 1'b0;
    test_random_traffic(500);
    wait_for_results();

    fail_count += head_reports_due.size();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every item waiting out a full sender gap,
  // the longest sequencer walk and a full receiver stall, plus the long hold-off.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
